// ===== hw/rtl/dbv_pkg.sv =====
// ----------------------------------------------------------------------------
// dbv_pkg
// Types, constants and helpers shared by the discovery beacon validator.
// ----------------------------------------------------------------------------
`default_nettype none

package dbv_pkg;

    localparam int MAX_DATAGRAM_DEF = 65535;
    localparam int HEADER_BYTES     = 13;
    localparam int IDX_W            = 17;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SMALL     = 3'd1,
        ST_MAGIC     = 3'd2,
        ST_VERSION   = 3'd3,
        ST_PARTITION = 3'd4,
        ST_SIZE      = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  type_len;
        logic [7:0]  name_len;
        logic [15:0] payload_len;
        logic [15:0] total_len;
    } out_item_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = 8'h00;
            2'd1:    b = 8'h44;
            2'd2:    b = 8'h53;
            default: b = 8'h44;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dbv_in_stage.sv =====
// ----------------------------------------------------------------------------
// dbv_in_stage
// Input register that holds one received byte until the checker takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dbv_in_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  dbv_pkg::in_item_t     in_data,
    input  wire logic             item_take,
    output logic                  item_valid,
    output dbv_pkg::in_item_t     item
);

    logic              valid_reg;
    logic              valid_next;
    dbv_pkg::in_item_t item_reg;
    logic              load;

    assign in_stall   = valid_reg && !item_take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dbv_hdr_check.sv =====
// ----------------------------------------------------------------------------
// dbv_hdr_check
// Header checker: counts bytes, checks and keeps header fields, and registers
// one verdict on the final byte of each datagram.
// ----------------------------------------------------------------------------
`default_nettype none

module dbv_hdr_check #(
    parameter int MAX_DATAGRAM = dbv_pkg::MAX_DATAGRAM_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  dbv_pkg::in_item_t     item,
    input  wire logic [31:0]      partition_id,
    output logic                  item_take,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output dbv_pkg::out_item_t    out_data
);

    localparam int CNT_W = $clog2(MAX_DATAGRAM + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DATAGRAM);

    logic [CNT_W-1:0]            count_reg, count_next, count_upd;
    dbv_pkg::status_t            err_reg, err_next, err_upd;
    logic [7:0]                  type_reg, type_next, type_upd;
    logic [7:0]                  name_reg, name_next, name_upd;
    logic [15:0]                 pay_reg, pay_next, pay_upd;
    logic                        out_valid_reg, out_valid_next;
    dbv_pkg::out_item_t          out_reg, out_next;
    logic                        slot_free;
    logic                        done;
    logic [dbv_pkg::IDX_W-1:0]   idx;
    logic [dbv_pkg::IDX_W-1:0]   expected;
    logic [7:0]                  part_byte;
    logic [7:0]                  b;
    logic                        bad;
    logic                        bad_part;

    assign slot_free = !out_valid_reg || !out_stall;
    assign item_take = item_valid && (!item.last || slot_free);
    assign done      = item_take && item.last;
    assign idx       = dbv_pkg::IDX_W'(count_reg);
    assign b         = item.data_byte;

    always_comb
    begin
        unique case (idx[1:0])
            2'd1:    part_byte = partition_id[31:24];
            2'd2:    part_byte = partition_id[23:16];
            2'd3:    part_byte = partition_id[15:8];
            default: part_byte = partition_id[7:0];
        endcase
    end

    always_comb
    begin
        count_upd = count_reg;
        err_upd   = err_reg;
        type_upd  = type_reg;
        name_upd  = name_reg;
        pay_upd   = pay_reg;
        bad       = 1'b0;
        bad_part  = (part_byte != b);
        if (count_reg < CNT_MAX)
        begin
            count_upd = count_reg + CNT_W'(1);
            priority if (idx < 17'd4)
            begin
                bad = (b != dbv_pkg::magic_byte(idx[1:0]));
                if (bad && err_reg == dbv_pkg::ST_OK)
                begin
                    err_upd = dbv_pkg::ST_MAGIC;
                end
            end
            else if (idx == 17'd4)
            begin
                if (b != 8'd0 && err_reg == dbv_pkg::ST_OK)
                begin
                    err_upd = dbv_pkg::ST_VERSION;
                end
            end
            else if (idx <= 17'd8)
            begin
                if (bad_part && err_reg == dbv_pkg::ST_OK)
                begin
                    err_upd = dbv_pkg::ST_PARTITION;
                end
            end
            else if (idx == 17'd9)
            begin
                type_upd = b;
            end
            else if (idx == 17'd10)
            begin
                name_upd = b;
            end
            else if (idx == 17'd11)
            begin
                pay_upd = {b, pay_reg[7:0]};
            end
            else if (idx == 17'd12)
            begin
                pay_upd = {pay_reg[15:8], b};
            end
            else
            begin
                bad = 1'b0;
            end
        end
    end

    assign expected = dbv_pkg::IDX_W'(dbv_pkg::HEADER_BYTES) + dbv_pkg::IDX_W'(type_upd)
                    + dbv_pkg::IDX_W'(name_upd) + dbv_pkg::IDX_W'(pay_upd);

    always_comb
    begin
        out_next             = out_reg;
        out_next.type_len    = type_upd;
        out_next.name_len    = name_upd;
        out_next.payload_len = pay_upd;
        out_next.total_len   = 16'(count_upd);
        priority if (dbv_pkg::IDX_W'(count_upd) < dbv_pkg::IDX_W'(dbv_pkg::HEADER_BYTES))
        begin
            out_next.status = dbv_pkg::ST_SMALL;
        end
        else if (err_upd != dbv_pkg::ST_OK)
        begin
            out_next.status = err_upd;
        end
        else if (dbv_pkg::IDX_W'(count_upd) != expected)
        begin
            out_next.status = dbv_pkg::ST_SIZE;
        end
        else
        begin
            out_next.status = dbv_pkg::ST_OK;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        err_next   = err_reg;
        type_next  = type_reg;
        name_next  = name_reg;
        pay_next   = pay_reg;
        if (done)
        begin
            count_next = '0;
            err_next   = dbv_pkg::ST_OK;
            type_next  = '0;
            name_next  = '0;
            pay_next   = '0;
        end
        else if (item_take)
        begin
            count_next = count_upd;
            err_next   = err_upd;
            type_next  = type_upd;
            name_next  = name_upd;
            pay_next   = pay_upd;
        end
    end

    assign out_valid_next = done || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            err_reg       <= dbv_pkg::ST_OK;
            type_reg      <= '0;
            name_reg      <= '0;
            pay_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            err_reg       <= err_next;
            type_reg      <= type_next;
            name_reg      <= name_next;
            pay_reg       <= pay_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/discovery_beacon_validator_top.sv =====
// ----------------------------------------------------------------------------
// discovery_beacon_validator_top
// Checks the header of a received discovery datagram byte by byte and gives
// one verdict with the kept length fields on the final byte.
// ----------------------------------------------------------------------------
//  channel  direction  handshake         payload
//  in       input      in_valid/in_stall   in_data  (data_byte, last)
//  out      output     out_valid/out_stall out_data (status, lengths)
//  cfg      input      cfg_valid/cfg_ready cfg_data (partition_id)
//
// One byte is accepted every cycle while in_stall is low; a verdict is
// registered in the result register when its final byte is taken from the
// input register. Reset clears the counter, the kept fields, the partition
// register and both valid flags. A stall on the output holds back only a final
// byte; other bytes keep flowing while a verdict waits.
// ----------------------------------------------------------------------------
`default_nettype none

module discovery_beacon_validator_top #(
    parameter int MAX_DATAGRAM = dbv_pkg::MAX_DATAGRAM_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  dbv_pkg::in_item_t     in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output dbv_pkg::out_item_t    out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [31:0]      cfg_data
);

    logic [31:0]       partition_reg;
    logic [31:0]       partition_next;
    logic              item_valid;
    logic              item_take;
    dbv_pkg::in_item_t item;

    assign cfg_ready      = 1'b1;
    assign partition_next = (cfg_valid && cfg_ready) ? cfg_data : partition_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partition_reg <= '0;
        end
        else
        begin
            partition_reg <= partition_next;
        end
    end

    dbv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .item_take  (item_take),
        .item_valid (item_valid),
        .item       (item)
    );

    dbv_hdr_check #(
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_hdr_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .partition_id (partition_reg),
        .item_take    (item_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

`ifndef SYNTHESIS
    // The input side is only held back while a verdict is waiting downstream.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked verdict");

    // A datagram shorter than the header is always reported as too small.
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.total_len < 16'(dbv_pkg::HEADER_BYTES))
        |-> (out_data.status == dbv_pkg::ST_SMALL))
        else $error("short datagram not reported as too small");

    // An accepted datagram has exactly the length that its header announces.
    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == dbv_pkg::ST_OK)
        |-> (17'(out_data.total_len) == 17'(dbv_pkg::HEADER_BYTES)
             + 17'(out_data.type_len) + 17'(out_data.name_len)
             + 17'(out_data.payload_len)))
        else $error("accepted datagram with inconsistent length");
`endif

endmodule

`default_nettype wire
